/* rtl/bmp_crop_pkg.sv */
`timescale 1ns / 1ps

package bmp_crop_pkg;

	// Source and window limits
	localparam int MAX_WIDTH       = 4096;
	localparam int MAX_HEIGHT      = 4096;
	localparam int BYTES_PER_PIXEL = 3;

	// Field widths
	localparam int DIM_W   = 13;  // src_width, src_height, crop_w, crop_h
	localparam int POS_W   = 12;  // crop_x, crop_y, row counter
	localparam int COL_W   = 14;  // byte-in-row counter
	localparam int CFG_W   = 13;  // widest register
	localparam int CFG_A_W = 3;
	localparam int BEAT_W  = 2;   // up to four beats per input byte

	typedef enum logic [CFG_A_W-1:0] {
		CFG_SRC_WIDTH  = 3'd0,
		CFG_SRC_HEIGHT = 3'd1,
		CFG_CROP_X     = 3'd2,
		CFG_CROP_Y     = 3'd3,
		CFG_CROP_W     = 3'd4,
		CFG_CROP_H     = 3'd5
	} cfg_idx_t;

	// Pads needed to bring 3*pixels up to a multiple of four: pixels mod 4
	function automatic logic [1:0] pad_for(input logic [DIM_W-1:0] pixels);
		return pixels[1:0];
	endfunction

	// Clamp a dimension into 1..max
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] max_v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > max_v) begin
			r = max_v;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* rtl/bmp_region_crop_stream.sv */
`timescale 1ns / 1ps

// Streaming region-of-interest crop for 24-bit images whose rows are padded to a
// multiple of four bytes. Source bytes enter one per beat in stored row order; the
// block counts the byte position in the row and the row number, passes on the bytes
// inside the window (crop_x, crop_y, crop_w, crop_h) and appends zero pads after the
// last window byte of each output row so that output rows are a multiple of four
// bytes too. row_end marks the last byte of an output row, image_end the last byte
// of the cropped image, and last the final output beat caused by one input byte.
// If the window does not fit inside the (clamped) source, nothing is passed and one
// beat with window_error set is given on the final source byte. Rate: one input byte
// per cycle; an input byte that closes an output row with pads yields 1 + pads output
// beats (up to four), and the input is stalled until the final beat of the byte held
// in the output register is taken. The decode is one pass of compare logic between
// the row counters and the output register, so a new byte is taken in the same cycle
// the previous byte's final beat leaves. Configuration is written with cfg_we,
// cfg_index, cfg_data while the block is idle; indexes above five are ignored.
module bmp_region_crop_stream
	import bmp_crop_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic [CFG_A_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         src_byte,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               row_end,
	output logic               last,
	output logic               image_end,
	output logic               window_error
);

	localparam logic [DIM_W-1:0] MAX_W_C = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_H_C = DIM_W'(MAX_HEIGHT);

	// Configuration registers
	logic [DIM_W-1:0] src_width_q, src_height_q, crop_w_q, crop_h_q;
	logic [POS_W-1:0] crop_x_q, crop_y_q;

	// Position counters
	logic [COL_W-1:0] col_q;
	logic [POS_W-1:0] row_q;

	// Output register: one input byte's worth of beats
	logic              out_valid_q;
	logic [BEAT_W-1:0] beat_q;
	logic [BEAT_W-1:0] final_beat_q;
	logic [7:0]        byte_q;
	logic              row_last_q;
	logic              img_last_q;
	logic              err_q;

	// Decode signals
	logic [DIM_W-1:0]   w_c, h_c;
	logic [COL_W:0]     row_bytes_ext;
	logic [COL_W-1:0]   row_bytes;
	logic               row_done, img_done, win_ok;
	logic [COL_W-1:0]   x_end, y_end, x0;
	logic [COL_W+1:0]   x1;
	logic               in_rows, in_cols, hit, row_last, img_last;
	logic [1:0]         pads;
	logic               accept, fin, take_final, produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= DIM_W'(1);
			src_height_q <= DIM_W'(1);
			crop_x_q     <= '0;
			crop_y_q     <= '0;
			crop_w_q     <= DIM_W'(1);
			crop_h_q     <= DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SRC_WIDTH:  src_width_q  <= cfg_data;
				CFG_SRC_HEIGHT: src_height_q <= cfg_data;
				CFG_CROP_X:     crop_x_q     <= cfg_data[POS_W-1:0];
				CFG_CROP_Y:     crop_y_q     <= cfg_data[POS_W-1:0];
				CFG_CROP_W:     crop_w_q     <= cfg_data;
				CFG_CROP_H:     crop_h_q     <= cfg_data;
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// Source row geometry: 3*w bytes plus pads
	always_comb begin
		w_c = clamp_dim(src_width_q, MAX_W_C);
		h_c = clamp_dim(src_height_q, MAX_H_C);
		row_bytes_ext = {2'b00, w_c} + {1'b0, w_c, 1'b0} + (COL_W+1)'(pad_for(w_c));
		row_bytes = row_bytes_ext[COL_W-1:0];
		// A counter at or beyond its end (after a mid-image write) counts as at the end
		row_done = ({1'b0, col_q} + (COL_W+1)'(1)) >= {1'b0, row_bytes};
		img_done = row_done && (({1'b0, row_q} + DIM_W'(1)) >= h_c);
	end

	// Window geometry
	always_comb begin
		x_end  = {2'b00, crop_x_q} + {1'b0, crop_w_q};
		y_end  = {2'b00, crop_y_q} + {1'b0, crop_h_q};
		win_ok = (crop_w_q != '0) && (crop_h_q != '0) &&
		         (x_end <= {1'b0, w_c}) && (y_end <= {1'b0, h_c});
		x0     = {2'b00, crop_x_q} + {1'b0, crop_x_q, 1'b0};
		x1     = {2'b00, x_end} + {1'b0, x_end, 1'b0};
		in_rows  = (row_q >= crop_y_q) && ({2'b00, row_q} < y_end);
		in_cols  = (col_q >= x0) && ({2'b00, col_q} < x1);
		hit      = win_ok && in_rows && in_cols;
		row_last = ({2'b00, col_q} + (COL_W+2)'(1)) == x1;
		img_last = row_last && (({2'b00, row_q} + COL_W'(1)) == y_end);
		pads     = row_last ? pad_for(crop_w_q) : 2'd0;
		produce  = hit || (!win_ok && img_done);
	end

	// Output beat decode
	assign fin        = (beat_q == final_beat_q);
	assign take_final = out_valid_q && !out_stall && fin;

	// Take a new byte when the output register is empty or its final beat leaves now
	assign in_stall = out_valid_q && !take_final;
	assign accept   = in_valid && !in_stall;

	// Advance the counters on every accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_done) begin
				col_q <= '0;
				row_q <= img_done ? '0 : row_q + POS_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			beat_q      <= '0;
		end else begin
			if (accept && produce) begin
				out_valid_q <= 1'b1;
				beat_q      <= '0;
			end else if (take_final) begin
				out_valid_q <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				beat_q <= beat_q + BEAT_W'(1);
			end
		end
	end

	// Output payload; loaded only with a new byte
	always_ff @(posedge clk) begin
		if (accept && produce) begin
			byte_q       <= src_byte;
			err_q        <= !win_ok;
			row_last_q   <= win_ok && row_last;
			img_last_q   <= win_ok && img_last;
			final_beat_q <= win_ok ? pads : 2'd0;
		end
	end

	// Beat zero carries the source byte; pad beats and the error beat carry zero
	assign out_valid    = out_valid_q;
	assign out_byte     = (beat_q == '0 && !err_q) ? byte_q : 8'h00;
	assign last         = fin;
	assign row_end      = fin && row_last_q;
	assign image_end    = fin && img_last_q;
	assign window_error = err_q;

`ifndef NO_ASSERTIONS
	// An error beat stands alone and marks no row or image end
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && window_error) |-> (last && !row_end && !image_end && out_byte == 8'h00))
		else $error("window error beat carries stray flags");

	// The image ends only on the last beat of an output row
	a_img_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && image_end) |-> (row_end && last))
		else $error("image_end without row_end and last");

	// A byte is taken while beats are pending only when the final one leaves
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && out_valid) |-> (last && !out_stall))
		else $error("input accepted over pending output beats");

	// A stalled beat that is not final must stay, not drop
	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |=> out_valid)
		else $error("pending pad beats lost");
`endif

endmodule
